FILE: sv/pdc_pkg.sv
// package for the packet digest checker: constants, md5 tables and the shared beat type
// used by pdc_front, pdc_queue, pdc_md5, pdc_back, packet_digest_checker_top and the bench
package pdc_pkg;

	localparam int MAX_DATA_BYTES = 16384;
	localparam int HEADER_BYTES = 20;
	localparam int PKT_MAX_LEN = HEADER_BYTES + MAX_DATA_BYTES;
	localparam int CNT_W = 15;
	localparam logic [31:0] MAGIC_RESET = 32'h0000_2B1C;
	localparam logic [CNT_W-1:0] DIGEST_OFFSET = CNT_W'(12);

	localparam logic [2:0] ST_GOOD = 3'd0;
	localparam logic [2:0] ST_LEN_RANGE = 3'd1;
	localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
	localparam logic [2:0] ST_BAD_DIGEST = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// queue entry from front to back
	typedef struct packed {
		logic [7:0] hb;
		logic last;
		logic [CNT_W-1:0] byte_count;
		logic overrun;
		logic [31:0] length_field;
		logic [31:0] type_field;
		logic [31:0] magic_field;
		logic [31:0] stored_digest;
	} beat_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
			32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
			32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
			32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
			32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
			32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
			32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
			32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
			32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
			32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
			32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
		return k[i];
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s [16];
		s = '{5'd7,5'd12,5'd17,5'd22,5'd5,5'd9,5'd14,5'd20,
			5'd4,5'd11,5'd16,5'd23,5'd6,5'd10,5'd15,5'd21};
		return s[{i[5:4], i[1:0]}];
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] r;
		r = i[3:0];
		unique case (i[5:4])
			2'd0: r = i[3:0];
			2'd1: r = 4'(5 * i[3:0] + 1);
			2'd2: r = 4'(3 * i[3:0] + 5);
			2'd3: r = 4'(7 * i[3:0]);
			default: r = i[3:0];
		endcase
		return r;
	endfunction

endpackage

FILE: sv/pdc_front.sv
// front end: descrambles bytes and captures header words and counts
// depends on pdc_pkg
module pdc_front import pdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic encrypted,
	input  logic last_byte,
	output logic push,
	output beat_t push_beat,
	input  logic q_full
);
	logic [CNT_W-1:0] cnt_q;
	logic ovr_q, scr_q;
	logic [31:0] len_q, typ_q, mag_q, dig_q;
	logic first, scr, acc, hdr;
	logic [7:0] b, r;
	logic [4:0] sh;
	logic [31:0] len_n, typ_n, mag_n, dig_n;
	logic [CNT_W-1:0] cnt_n;
	logic ovr_n;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;
	assign first = (cnt_q == '0) && !ovr_q;
	assign scr = first ? encrypted : scr_q;
	assign r = {data_byte[2:0], data_byte[7:3]};
	assign b = (scr && (ovr_q || cnt_q >= CNT_W'(4))) ? ~r : data_byte;
	assign hdr = !ovr_q && (cnt_q < CNT_W'(HEADER_BYTES));
	assign sh = {cnt_q[1:0], 3'b000};

	always_comb begin
		len_n = len_q;
		typ_n = typ_q;
		mag_n = mag_q;
		dig_n = dig_q;
		if (hdr) begin
			unique case (cnt_q[4:2])
				3'd0: len_n = len_q | ({24'd0, b} << sh);
				3'd1: typ_n = typ_q | ({24'd0, b} << sh);
				3'd2: mag_n = mag_q | ({24'd0, b} << sh);
				3'd3: dig_n = dig_q | ({24'd0, b} << sh);
				default: ;
			endcase
		end
		if (cnt_q < CNT_W'(PKT_MAX_LEN)) begin
			cnt_n = cnt_q + 1'b1;
			ovr_n = ovr_q;
		end else begin
			cnt_n = cnt_q;
			ovr_n = 1'b1;
		end
	end

	assign push = acc;
	always_comb begin
		push_beat.hb = (hdr && cnt_q[4:2] == DIGEST_OFFSET[4:2]) ? 8'd0 : b;
		push_beat.last = last_byte;
		push_beat.byte_count = cnt_n;
		push_beat.overrun = ovr_n;
		push_beat.length_field = len_n;
		push_beat.type_field = typ_n;
		push_beat.magic_field = mag_n;
		push_beat.stored_digest = dig_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovr_q <= 1'b0;
			scr_q <= 1'b0;
			len_q <= '0;
			typ_q <= '0;
			mag_q <= '0;
			dig_q <= '0;
		end else if (acc) begin
			if (last_byte) begin
				cnt_q <= '0;
				ovr_q <= 1'b0;
				scr_q <= 1'b0;
				len_q <= '0;
				typ_q <= '0;
				mag_q <= '0;
				dig_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				ovr_q <= ovr_n;
				scr_q <= scr;
				len_q <= len_n;
				typ_q <= typ_n;
				mag_q <= mag_n;
				dig_q <= dig_n;
			end
		end
	end
endmodule

FILE: sv/pdc_queue.sv
// small fifo between front and back end
// depends on pdc_pkg
module pdc_queue import pdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  beat_t push_beat,
	output logic full,
	input  logic pop,
	output logic empty,
	output beat_t head
);
	beat_t mem_q [QDEPTH];
	logic [QPTR_W:0] wp_q, rp_q;

	assign empty = wp_q == rp_q;
	assign full = (wp_q[QPTR_W] != rp_q[QPTR_W]) && (wp_q[QPTR_W-1:0] == rp_q[QPTR_W-1:0]);
	assign head = mem_q[rp_q[QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q[QPTR_W-1:0]] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end
endmodule

FILE: sv/pdc_md5.sv
// md5 compression unit, one round per cycle over the 64 rounds
// depends on pdc_pkg
module pdc_md5 import pdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] chain_in [4],
	input  logic [31:0] words [16],
	output logic busy,
	output logic [31:0] chain_out [4]
);
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0] rnd_q;
	logic [31:0] f, t, rot;
	logic [4:0] s;

	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = '0;
		endcase
		t = f + a_q + md5_k(rnd_q) + words[md5_g(rnd_q)];
		s = md5_s(rnd_q);
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	assign chain_out[0] = chain_in[0] + a_q;
	assign chain_out[1] = chain_in[1] + b_q;
	assign chain_out[2] = chain_in[2] + c_q;
	assign chain_out[3] = chain_in[3] + d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			rnd_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			rnd_q <= '0;
		end else if (busy) begin
			rnd_q <= rnd_q + 1'b1;
			if (rnd_q == 6'd63) begin
				busy <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= chain_in[0];
			b_q <= chain_in[1];
			c_q <= chain_in[2];
			d_q <= chain_in[3];
		end else if (busy) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end
endmodule

FILE: sv/pdc_back.sv
// back end: assembles blocks, runs md5, pads, folds and checks
// depends on pdc_pkg and pdc_md5
module pdc_back import pdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [31:0] expected_magic,
	input  logic q_empty,
	input  beat_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [31:0] computed_digest,
	output logic [31:0] packet_type,
	output logic [CNT_W-1:0] packet_length
);
	typedef enum logic [7:0] {
		S_TAKE = 8'b00000001,
		S_HASH = 8'b00000010,
		S_PAD = 8'b00000100,
		S_PAD1 = 8'b00001000,
		S_FIN = 8'b00010000,
		S_FIN1 = 8'b00100000,
		S_FIN2 = 8'b01000000,
		S_OUT = 8'b10000000
	} state_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	state_t st_q;
	logic [31:0] w_q [16];
	logic [31:0] ch_q [4];
	logic [31:0] co [4];
	logic [5:0] pos_q;
	logic last_q;
	beat_t pkt_q;
	logic start, busy;
	logic [3:0] wi;
	logic [4:0] sh;
	logic [31:0] dig;

	pdc_md5 u_md5 (
		.clk(clk), .arst_n(arst_n), .start(start), .chain_in(ch_q),
		.words(w_q), .busy(busy), .chain_out(co)
	);

	assign pop = (st_q == S_TAKE) && !q_empty;
	assign out_valid = st_q == S_OUT;
	assign wi = pos_q[5:2];
	assign sh = {pos_q[1:0], 3'b000};
	assign dig = co[0] ^ co[1] ^ co[2] ^ co[3];
	assign packet_type = pkt_q.type_field;
	assign packet_length = pkt_q.byte_count;
	assign start = (st_q == S_TAKE && pop && pos_q == 6'd63)
		|| st_q == S_PAD1 || st_q == S_FIN1;

	always_ff @(posedge clk) begin
		if (pop) begin
			pkt_q <= head;
			last_q <= head.last;
			if (pos_q[1:0] == 2'd0) begin
				w_q[wi] <= {24'd0, head.hb};
			end else begin
				w_q[wi] <= w_q[wi] | ({24'd0, head.hb} << sh);
			end
		end else if (st_q == S_PAD) begin
			for (int i = 0; i < 16; i++) begin
				if (4'(i) == wi) begin
					w_q[i] <= (pos_q[1:0] == 2'd0) ? 32'h80
						: ((w_q[i] & ((32'd1 << sh) - 32'd1)) | (32'h80 << sh));
				end else if (4'(i) > wi) begin
					w_q[i] <= '0;
				end
			end
		end else if (st_q == S_PAD1) begin
			if (pos_q < 6'd56) begin
				w_q[14] <= {14'd0, pkt_q.byte_count, 3'd0};
				w_q[15] <= '0;
			end
		end else if (st_q == S_FIN && pos_q >= 6'd56 && !busy) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= '0;
			end
			w_q[14] <= {14'd0, pkt_q.byte_count, 3'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_TAKE;
			pos_q <= '0;
			ch_q <= '{IV0, IV1, IV2, IV3};
			status <= ST_GOOD;
			computed_digest <= '0;
		end else begin
			unique case (st_q)
				S_TAKE: begin
					if (pop) begin
						if (pos_q == 6'd63) begin
							st_q <= S_HASH;
						end else if (head.last) begin
							st_q <= S_PAD;
						end
						pos_q <= pos_q + 1'b1;
					end
				end
				S_HASH: begin
					if (!busy) begin
						ch_q <= co;
						st_q <= last_q ? S_PAD : S_TAKE;
					end
				end
				S_PAD: st_q <= S_PAD1;
				S_PAD1: begin
					// with room for the length one compression ends it
					st_q <= (pos_q < 6'd56) ? S_FIN2 : S_FIN;
				end
				S_FIN: begin
					if (!busy) begin
						ch_q <= co;
						st_q <= S_FIN1;
					end
				end
				S_FIN1: st_q <= S_FIN2;
				S_FIN2: begin
					if (!busy && !start) begin
						computed_digest <= dig;
						if (pkt_q.length_field < 32'(HEADER_BYTES)
								|| pkt_q.length_field > 32'(PKT_MAX_LEN)) begin
							status <= ST_LEN_RANGE;
						end else if (pkt_q.overrun
								|| pkt_q.length_field != 32'(pkt_q.byte_count)) begin
							status <= ST_LEN_MISMATCH;
						end else if (pkt_q.magic_field != expected_magic) begin
							status <= ST_BAD_MAGIC;
						end else if (pkt_q.stored_digest != dig) begin
							status <= ST_BAD_DIGEST;
						end else begin
							status <= ST_GOOD;
						end
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						st_q <= S_TAKE;
						pos_q <= '0;
						ch_q <= '{IV0, IV1, IV2, IV3};
					end
				end
				default: st_q <= S_TAKE;
			endcase
		end
	end
endmodule

FILE: sv/packet_digest_checker_top.sv
// top level of the packet digest checker: front, queue and md5 back end
// depends on pdc_pkg, pdc_front, pdc_queue, pdc_back
// Bytes enter one per beat and are gathered into 64-byte blocks, each compressed by the
// one-round-per-cycle md5 unit; a packet end adds padding, one or two final compressions
// and the result beat. The 4-entry queue absorbs up to four beats while a block is
// compressed, then the input stalls.
module packet_digest_checker_top import pdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata, // data_byte
	input  logic s_tuser, // encrypted
	input  logic s_tlast, // last_byte
	output logic m_tvalid,
	input  logic m_tready,
	output logic [87:0] m_tdata // status, computed_digest, packet_type, packet_length, pad
);
	logic [31:0] magic_q;
	logic push, full, pop, empty;
	beat_t pb, hd;
	logic [2:0] status;
	logic [31:0] dig, typ;
	logic [CNT_W-1:0] len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (cfg_we) begin
			magic_q <= cfg_wdata;
		end
	end

	pdc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.data_byte(s_tdata), .encrypted(s_tuser), .last_byte(s_tlast),
		.push(push), .push_beat(pb), .q_full(full)
	);

	pdc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_beat(pb), .full(full),
		.pop(pop), .empty(empty), .head(hd)
	);

	pdc_back u_back (
		.clk(clk), .arst_n(arst_n), .expected_magic(magic_q), .q_empty(empty),
		.head(hd), .pop(pop), .out_valid(m_tvalid), .out_ready(m_tready),
		.status(status), .computed_digest(dig), .packet_type(typ), .packet_length(len)
	);

	assign m_tdata = {6'd0, len, typ, dig, status};
endmodule

FILE: bench/tb.sv
// testbench for packet_digest_checker_top: drives byte streams of packets and checks results
// against an md5 based predictor kept in this file; depends on pdc_pkg and the rtl in sv/
`timescale 1ns / 100ps

module tb;
	import pdc_pkg::*;

	typedef logic [7:0] u8_t;
	typedef logic [15:0][31:0] blk_t;
	typedef logic [3:0][31:0] chain_t;

	typedef struct {
		logic [2:0] status;
		logic [31:0] digest;
		logic [31:0] ptype;
		logic [14:0] plen;
	} verdict_t;

	typedef enum int {PK_GOOD, PK_BAD_RANGE, PK_OFF_BY_ONE, PK_BAD_MAGIC, PK_BAD_DIGEST,
		PK_NOISE} pkt_kind_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
		32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
		32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
		32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
		32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
		32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
		32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
		32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
		32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
		32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
		32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
	localparam int S_TAB [16] = '{7,12,17,22,5,9,14,20,4,11,16,23,6,10,15,21};
	localparam chain_t IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
	localparam int LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [87:0] m_tdata;

	packet_digest_checker_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	verdict_t verdict_q[$];
	int errors = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int packets_sent = 0;
	int verdicts_seen = 0;
	bit no_idle = 0;

	// predictor state
	logic [31:0] magic_reg;
	chain_t pr_chain;
	blk_t pr_words;
	int pr_cnt;
	int pr_pos;
	bit pr_ovr;
	bit pr_scr;
	logic [31:0] pr_len, pr_type, pr_magic, pr_dig;

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	function automatic chain_t md5_block(chain_t c, blk_t w);
		logic [31:0] a, b, cc, d, f;
		int g;
		a = c[0]; b = c[1]; cc = c[2]; d = c[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & cc) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & cc); g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ cc ^ d; g = (3 * i + 5) % 16;
			end else begin
				f = cc ^ (b | ~d); g = (7 * i) % 16;
			end
			f = f + a + K_TAB[i] + w[g];
			a = d; d = cc; cc = b;
			b = b + rol(f, S_TAB[(i / 16) * 4 + (i % 4)]);
		end
		c[0] += a; c[1] += b; c[2] += cc; c[3] += d;
		return c;
	endfunction

	function automatic logic [31:0] fold(chain_t c);
		return c[0] ^ c[1] ^ c[2] ^ c[3];
	endfunction

	// md5 of a whole message folded to one word, used to build packets with a correct digest word
	function automatic logic [31:0] message_digest(u8_t m[$]);
		u8_t p[$];
		chain_t c;
		blk_t w;
		longint bits;
		p = m;
		bits = longint'(m.size()) * 8;
		p.push_back(8'h80);
		while (p.size() % 64 != 56) p.push_back(8'h00);
		for (int i = 0; i < 8; i++) p.push_back(u8_t'(bits >> (8 * i)));
		c = IV;
		for (int blk = 0; blk < p.size() / 64; blk++) begin
			for (int j = 0; j < 16; j++)
				w[j] = {p[blk*64+j*4+3], p[blk*64+j*4+2], p[blk*64+j*4+1], p[blk*64+j*4]};
			c = md5_block(c, w);
		end
		return fold(c);
	endfunction

	function automatic void clear_packet_state();
		pr_chain = IV; pr_words = '0; pr_cnt = 0; pr_pos = 0; pr_ovr = 0; pr_scr = 0;
		pr_len = '0; pr_type = '0; pr_magic = '0; pr_dig = '0;
	endfunction

	function automatic logic [31:0] close_digest();
		blk_t w;
		chain_t c;
		int wi, sh;
		logic [31:0] keep;
		w = pr_words; c = pr_chain;
		wi = pr_pos / 4; sh = (pr_pos % 4) * 8;
		keep = (sh == 0) ? 32'h0 : (w[wi] & ((32'h1 << sh) - 1));
		w[wi] = keep | (32'h80 << sh);
		for (int i = wi + 1; i < 16; i++) w[i] = '0;
		if (pr_pos >= 56) begin
			c = md5_block(c, w);
			w = '0;
		end
		w[14] = 32'(pr_cnt * 8);
		w[15] = '0;
		c = md5_block(c, w);
		return fold(c);
	endfunction

	function automatic void predict_beat(u8_t din, bit enc, bit last);
		logic [31:0] b, hb, dg;
		int off, sh;
		verdict_t v;
		b = {24'h0, din};
		off = pr_cnt;
		if (pr_cnt == 0 && !pr_ovr) pr_scr = enc;
		if (pr_scr && (pr_ovr || off >= 4)) b = {24'h0, ~{din[2:0], din[7:3]}};
		hb = b;
		if (!pr_ovr && off < HEADER_BYTES) begin
			sh = (off % 4) * 8;
			case (off / 4)
				0: pr_len |= b << sh;
				1: pr_type |= b << sh;
				2: pr_magic |= b << sh;
				3: begin
					pr_dig |= b << sh; hb = 0;
				end
				default: ;
			endcase
		end
		sh = (pr_pos % 4) * 8;
		if (sh == 0) pr_words[pr_pos / 4] = hb;
		else pr_words[pr_pos / 4] |= hb << sh;
		pr_pos++;
		if (pr_pos >= 64) begin
			pr_chain = md5_block(pr_chain, pr_words);
			pr_pos = 0;
		end
		if (pr_cnt < PKT_MAX_LEN) pr_cnt++;
		else pr_ovr = 1;
		if (!last) return;
		dg = close_digest();
		if (pr_len < HEADER_BYTES || pr_len > PKT_MAX_LEN) v.status = ST_LEN_RANGE;
		else if (pr_ovr || pr_len != 32'(pr_cnt)) v.status = ST_LEN_MISMATCH;
		else if (pr_magic != magic_reg) v.status = ST_BAD_MAGIC;
		else if (pr_dig != dg) v.status = ST_BAD_DIGEST;
		else v.status = ST_GOOD;
		v.digest = dg; v.ptype = pr_type; v.plen = 15'(pr_cnt);
		verdict_q.push_back(v);
		clear_packet_state();
	endfunction

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < 9);
	endfunction

	task automatic send_beat(u8_t d, bit enc, bit last);
		while (idle_now()) begin
			@(negedge clk);
			s_tvalid = 0;
			s_tdata = 8'($urandom);
			s_tuser = 1'($urandom);
			s_tlast = 1'($urandom);
		end
		@(negedge clk);
		s_tvalid = 1; s_tdata = d; s_tuser = enc; s_tlast = last;
		do @(posedge clk); while (!s_tready);
		predict_beat(d, enc, last);
		bytes_sent++;
	endtask

	// builds n plain packet bytes, scrambles bytes 4 on if enc and not noise, and sends them
	task automatic send_packet(int n, bit enc, pkt_kind_t kind);
		u8_t p[$];
		u8_t hdr[20];
		u8_t inv;
		logic [31:0] lenw, magw, digw, typw;
		lenw = 32'(n); magw = magic_reg; typw = $urandom; digw = '0;
		if (kind == PK_BAD_RANGE) begin
			case ($urandom_range(3))
				0: lenw = $urandom_range(HEADER_BYTES - 1);
				1: lenw = PKT_MAX_LEN + 1;
				2: lenw = 32'hFFFF_FFFF;
				default: lenw = $urandom | 32'h8000_0000;
			endcase
		end
		if (kind == PK_OFF_BY_ONE) lenw = ($urandom_range(1)) ? 32'(n + 1) : 32'(n - 1);
		if (kind == PK_BAD_MAGIC) magw = magic_reg ^ (32'h1 << $urandom_range(31));
		for (int i = 0; i < 4; i++) begin
			hdr[i] = u8_t'(lenw >> (8 * i));
			hdr[4+i] = u8_t'(typw >> (8 * i));
			hdr[8+i] = u8_t'(magw >> (8 * i));
			hdr[12+i] = 8'h00;
		end
		for (int i = 16; i < 20; i++) hdr[i] = u8_t'($urandom);
		for (int i = 0; i < n; i++) p.push_back(i < 20 ? hdr[i] : u8_t'($urandom));
		if (kind != PK_NOISE && n >= 16) begin
			digw = message_digest(p);
			if (kind == PK_BAD_DIGEST) digw ^= 32'h1 << $urandom_range(31);
			for (int i = 0; i < 4; i++) p[12+i] = u8_t'(digw >> (8 * i));
		end
		if (kind == PK_NOISE) foreach (p[i]) p[i] = u8_t'($urandom);
		else if (enc) for (int i = 4; i < n; i++) begin
			inv = ~p[i];
			p[i] = {inv[4:0], inv[7:5]};
		end
		foreach (p[i]) send_beat(p[i], (i == 0) ? enc : 1'($urandom), i == n - 1);
		packets_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_magic(logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_we = 1; cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0; cfg_wdata = $urandom;
		magic_reg = v;
	endtask

	always @(negedge clk) m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);

	always @(posedge clk) begin
		verdict_t v;
		if (m_tvalid && m_tready) begin
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				v = verdict_q.pop_front();
				if (m_tdata[2:0] !== v.status) begin
					$error("status exp %0d got %0d", v.status, m_tdata[2:0]); errors++;
				end
				if (m_tdata[34:3] !== v.digest) begin
					$error("computed_digest exp %h got %h", v.digest, m_tdata[34:3]); errors++;
				end
				if (m_tdata[66:35] !== v.ptype) begin
					$error("packet_type exp %h got %h", v.ptype, m_tdata[66:35]); errors++;
				end
				if (m_tdata[81:67] !== v.plen) begin
					$error("packet_length exp %0d got %0d", v.plen, m_tdata[81:67]); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_packet(20, 0, PK_GOOD);
		send_packet(20, 1, PK_GOOD);
		send_packet(1, 0, PK_GOOD);
		send_packet(7, 1, PK_GOOD);
		send_packet(15, 0, PK_NOISE);
		send_packet(19, 1, PK_GOOD);
		send_packet(55, 0, PK_GOOD);
		send_packet(56, 1, PK_GOOD);
		send_packet(63, 0, PK_GOOD);
		send_packet(64, 1, PK_GOOD);
		send_packet(65, 0, PK_GOOD);
		send_packet(30, 0, PK_BAD_RANGE);
		send_packet(30, 1, PK_OFF_BY_ONE);
		send_packet(30, 0, PK_BAD_MAGIC);
		send_packet(30, 1, PK_BAD_DIGEST);
		send_packet(40, 1, PK_NOISE);
	endtask

	task automatic test_config_extremes();
		write_magic(32'h0000_0000);
		send_packet(24, 0, PK_GOOD);
		send_packet(24, 1, PK_BAD_MAGIC);
		write_magic(32'hFFFF_FFFF);
		send_packet(24, 1, PK_GOOD);
		send_packet(24, 0, PK_BAD_MAGIC);
		write_magic(MAGIC_RESET);
	endtask

	task automatic test_random();
		int start, n, r;
		pkt_kind_t kind;
		start = bytes_sent;
		while (bytes_sent - start < 950) begin
			if (($urandom_range(39)) == 0) write_magic($urandom);
			no_idle = (bytes_sent - start > 600) && (bytes_sent - start < 900);
			r = $urandom_range(99);
			n = (r < 80) ? $urandom_range(20, 90) : (r < 90) ? $urandom_range(1, 19)
				: $urandom_range(90, 300);
			r = $urandom_range(99);
			kind = (r < 70) ? PK_GOOD : (r < 76) ? PK_BAD_RANGE : (r < 82) ? PK_OFF_BY_ONE
				: (r < 88) ? PK_BAD_MAGIC : (r < 94) ? PK_BAD_DIGEST : PK_NOISE;
			send_packet(n, 1'($urandom), kind);
		end
		no_idle = 0;
	endtask

	initial begin
		magic_reg = MAGIC_RESET;
		clear_packet_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_config_extremes();
		test_random();
		drain();
		$display("%0d packets, %0d bytes, %0d results checked", packets_sent, bytes_sent,
			verdicts_seen);
		$display("covered all status codes, scrambled and plain, short and multi-block packets");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: packet_digest_checker_top.f
sv/pdc_pkg.sv
sv/pdc_front.sv
sv/pdc_queue.sv
sv/pdc_md5.sv
sv/pdc_back.sv
sv/packet_digest_checker_top.sv
bench/tb.sv
